>>> rtl/nfa_stream_acceptor_macros.svh
// Assertion macros shared by the acceptor RTL.
// Each use expects clk and rst in scope; no other dependencies.
`ifndef NFA_STREAM_ACCEPTOR_MACROS_SVH
`define NFA_STREAM_ACCEPTOR_MACROS_SVH

// Same-cycle implication, held off during reset.
`define NSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, held off during reset.
`define NSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/nsa_pkg.sv
// Shared types and constants for the automaton acceptor.
// No dependencies; imported by nsa_front, nsa_back, the top level and the bench.
`default_nettype none

package nsa_pkg;

  localparam int KIND_W        = 2;
  localparam int SLOT_W        = 4;
  localparam int SYMBOL_W      = 8;
  localparam int STATE_FIELD_W = 4;
  localparam int COUNT_W       = 5;
  localparam int FINAL_W       = 16;
  localparam int CFG_DATA_W    = 16;
  localparam int CFG_INDEX_W   = 1;

  localparam int DEF_NUM_STATES  = 16;
  localparam int DEF_NUM_SYMBOLS = 16;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam logic [CFG_INDEX_W-1:0] CFG_INITIAL_COUNT = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FINAL_MASK    = 1'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ADD    = 2'd1,
    KIND_SYMBOL = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  // Classified word handed from front to back.
  typedef struct packed {
    kind_t kind;
    logic  known;
  } cmd_t;

  localparam int CMD_W = $bits(cmd_t);

endpackage

`default_nettype wire

>>> rtl/nsa_front.sv
// Front end: vocabulary store, symbol lookup and word classification.
// Depends on nsa_pkg and the assertion macro header.
`default_nettype none
`include "nfa_stream_acceptor_macros.svh"

module nsa_front #(
  parameter int NUM_STATES  = nsa_pkg::DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = nsa_pkg::DEF_NUM_SYMBOLS
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    accept,
  input  wire logic [nsa_pkg::KIND_W-1:0]              kind,
  input  wire logic [nsa_pkg::SLOT_W-1:0]              slot,
  input  wire logic [nsa_pkg::SYMBOL_W-1:0]            symbol,
  input  wire logic [nsa_pkg::STATE_FIELD_W-1:0]       from_state,
  input  wire logic [nsa_pkg::STATE_FIELD_W-1:0]       to_state,
  output nsa_pkg::cmd_t                                push_cmd,
  output logic                                         push,
  output logic [$clog2(NUM_SYMBOLS)-1:0]               push_sidx,
  output logic [$clog2(NUM_STATES)-1:0]                push_from,
  output logic [$clog2(NUM_STATES)-1:0]                push_to
);
  import nsa_pkg::*;

  localparam int SYM_IDX_W   = $clog2(NUM_SYMBOLS);
  localparam int STATE_IDX_W = $clog2(NUM_STATES);

  logic [SYMBOL_W-1:0]  vocab_symbols [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] vocab_valid;

  kind_t                kind_in;
  logic                 slot_ok;
  logic                 states_ok;
  logic                 known;
  logic [SYM_IDX_W-1:0] hit_idx;
  logic [SYM_IDX_W-1:0] load_idx;

  assign kind_in  = kind_t'(kind);
  assign slot_ok  = int'(slot) < NUM_SYMBOLS;
  assign load_idx = SYM_IDX_W'(slot);
  assign states_ok = (int'(from_state) < NUM_STATES) && (int'(to_state) < NUM_STATES);

  // lowest valid matching slot wins
  always_comb begin
    known   = 1'b0;
    hit_idx = '0;
    for (int i = NUM_SYMBOLS - 1; i >= 0; i--) begin
      if (vocab_valid[i] && vocab_symbols[i] == symbol) begin
        known   = 1'b1;
        hit_idx = SYM_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vocab_valid <= '0;
    end else if (accept && kind_in == KIND_LOAD && slot_ok) begin
      vocab_valid[load_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind_in == KIND_LOAD && slot_ok) begin
      vocab_symbols[load_idx] <= symbol;
    end
  end

  // loads finish here; dead transitions are dropped
  always_comb begin
    push_cmd.kind  = kind_in;
    push_cmd.known = known;
    push_sidx      = hit_idx;
    push_from      = STATE_IDX_W'(from_state);
    push_to        = STATE_IDX_W'(to_state);
    case (kind_in)
      KIND_LOAD:   push = 1'b0;
      KIND_ADD:    push = accept && known && states_ok;
      KIND_SYMBOL: push = accept;
      KIND_END:    push = accept;
      default:     push = 1'b0;
    endcase
  end

  `NSA_ASSERT_NEXT(a_load_marks_valid, accept && kind_in == KIND_LOAD && slot_ok, vocab_valid[$past(load_idx)], "vocabulary load did not mark slot valid")
  `NSA_ASSERT_IMPL(a_push_known_add, push && kind_in == KIND_ADD, known, "transition queued for unknown symbol")

endmodule

`default_nettype wire

>>> rtl/nsa_queue.sv
// Short FIFO decoupling the front end from the back end.
// Depends on the assertion macro header only.
`default_nettype none
`include "nfa_stream_acceptor_macros.svh"

module nsa_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  full,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [CNT_W-1:0] count_next;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head_data  = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push) begin
      wr_ptr_next = (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `NSA_ASSERT_IMPL(a_pop_not_empty, pop, count != '0, "pop from empty queue")
  `NSA_ASSERT_IMPL(a_push_not_full, push, !full, "push into full queue")

endmodule

`default_nettype wire

>>> rtl/nsa_back.sv
// Back end: transition memory, active state set, config registers, result register.
// Depends on nsa_pkg and the assertion macro header.
`default_nettype none
`include "nfa_stream_acceptor_macros.svh"

module nsa_back #(
  parameter int NUM_STATES  = nsa_pkg::DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = nsa_pkg::DEF_NUM_SYMBOLS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [nsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [nsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               q_valid,
  input  wire nsa_pkg::cmd_t                      q_cmd,
  input  wire logic [$clog2(NUM_SYMBOLS)-1:0]     q_sidx,
  input  wire logic [$clog2(NUM_STATES)-1:0]      q_from,
  input  wire logic [$clog2(NUM_STATES)-1:0]      q_to,
  output logic                                    q_pop,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    accepted
);
  import nsa_pkg::*;

  localparam int NS          = NUM_STATES;
  localparam int STATE_IDX_W = $clog2(NUM_STATES);

  typedef logic [NS-1:0][NS-1:0] row_t;

  // one row per slot: a next-state mask for each source state
  row_t                   trans_mem [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0] row_valid;

  logic [COUNT_W-1:0] initial_count;
  logic [FINAL_W-1:0] final_mask;
  logic [NS-1:0]      active;
  logic [NS-1:0]      active_next;

  logic  b2_valid;
  kind_t b2_kind;
  logic  b2_known;
  logic  b2_row_ok;
  row_t  rd_row;

  logic               b2_done;
  logic               out_free;
  logic               wr_en;
  logic               rd_en;
  row_t               wr_mask;
  row_t               wr_bits;
  logic               cfg_count_we;
  logic [COUNT_W-1:0] count_sel;
  logic [NS-1:0]      init_set;
  logic [NS-1:0]      step_set;
  logic [NS-1:0]      final_ext;

  assign out_free = !out_valid || !out_stall;
  assign b2_done  = b2_valid && (b2_kind != KIND_END || out_free);
  assign q_pop    = q_valid && (!b2_valid || b2_done);
  assign wr_en    = q_pop && q_cmd.kind == KIND_ADD;
  assign rd_en    = q_pop && q_cmd.kind == KIND_SYMBOL;

  assign cfg_count_we = cfg_we && cfg_index == CFG_INITIAL_COUNT;
  assign count_sel    = cfg_count_we ? cfg_data[COUNT_W-1:0] : initial_count;
  assign final_ext    = NS'(final_mask);

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      init_set[i] = int'(count_sel) > i;
    end
  end

  // a fresh row is written whole so stale contents never show
  always_comb begin
    for (int f = 0; f < NS; f++) begin
      for (int t = 0; t < NS; t++) begin
        wr_bits[f][t] = (STATE_IDX_W'(f) == q_from) && (STATE_IDX_W'(t) == q_to);
        wr_mask[f][t] = row_valid[q_sidx] ? wr_bits[f][t] : 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int f = 0; f < NS; f++) begin
        for (int t = 0; t < NS; t++) begin
          if (wr_mask[f][t]) begin
            trans_mem[q_sidx][f][t] <= wr_bits[f][t];
          end
        end
      end
    end
    if (rd_en) begin
      rd_row <= trans_mem[q_sidx];
    end
  end

  always_comb begin
    step_set = '0;
    if (b2_known && b2_row_ok) begin
      for (int s = 0; s < NS; s++) begin
        if (active[s]) begin
          step_set = step_set | rd_row[s];
        end
      end
    end
  end

  always_comb begin
    active_next = active;
    if (cfg_count_we) begin
      active_next = init_set;
    end else if (b2_done) begin
      case (b2_kind)
        KIND_SYMBOL: active_next = step_set;
        KIND_END:    active_next = init_set;
        default:     active_next = active;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      initial_count <= COUNT_W'(1);
      final_mask    <= '0;
      active        <= NS'(1);
      b2_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid[q_sidx] <= 1'b1;
      end
      if (cfg_count_we) begin
        initial_count <= cfg_data[COUNT_W-1:0];
      end
      if (cfg_we && cfg_index == CFG_FINAL_MASK) begin
        final_mask <= cfg_data[FINAL_W-1:0];
      end
      active <= active_next;
      if (q_pop) begin
        b2_valid <= 1'b1;
      end else if (b2_done) begin
        b2_valid <= 1'b0;
      end
      if (b2_done && b2_kind == KIND_END) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_kind   <= q_cmd.kind;
      b2_known  <= q_cmd.known;
      b2_row_ok <= row_valid[q_sidx];
    end
    if (b2_done && b2_kind == KIND_END) begin
      accepted <= |(active & final_ext);
    end
  end

  `NSA_ASSERT_IMPL(a_result_from_end, out_valid && !$past(out_valid), $past(b2_valid && b2_kind == KIND_END), "result raised without an end word")
  `NSA_ASSERT_NEXT(a_end_held, b2_valid && b2_kind == KIND_END && !out_free, b2_valid && b2_kind == KIND_END, "end word lost while result stalled")

endmodule

`default_nettype wire

>>> rtl/nfa_stream_acceptor.sv
// Finite automaton acceptor over a word stream, DFA and NFA alike, with
// the active states held as a bit set. Each input word is one of four
// kinds: load a vocabulary slot, add a transition, feed a string symbol, or
// end a string; only an end word gives a result (accepted). A word is taken
// every cycle unless the queue is full: the front end classifies it and looks
// its symbol up in the vocabulary in the cycle it arrives, and a four-word
// queue feeds the back end, which reads one row of the transition memory per
// symbol and updates the active set in the following cycle. The loop that
// sets the rate is the active-set update, one OR over the masks of one memory
// row, so one word per cycle is sustained unless stalled. A registered result
// plus the queue let input keep flowing while a result is stalled, until the
// queue fills. All stores clear at reset through valid bits, so there is no
// clearing pass. Configuration (initial state count, final-state mask)
// must be written through cfg_we/cfg_index/cfg_data by the user only while
// the block is idle, which the block does not enforce; writing the count also
// reloads the active set. Depends on nsa_pkg, nsa_front, nsa_queue, nsa_back.
`default_nettype none

module nfa_stream_acceptor #(
  parameter int NUM_STATES  = nsa_pkg::DEF_NUM_STATES,
  parameter int NUM_SYMBOLS = nsa_pkg::DEF_NUM_SYMBOLS,
  parameter int QUEUE_DEPTH = nsa_pkg::DEF_QUEUE_DEPTH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [nsa_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [nsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [nsa_pkg::KIND_W-1:0]         kind,
  input  wire logic [nsa_pkg::SLOT_W-1:0]         slot,
  input  wire logic [nsa_pkg::SYMBOL_W-1:0]       symbol,
  input  wire logic [nsa_pkg::STATE_FIELD_W-1:0]  from_state,
  input  wire logic [nsa_pkg::STATE_FIELD_W-1:0]  to_state,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    accepted
);
  import nsa_pkg::*;

  localparam int SYM_IDX_W   = $clog2(NUM_SYMBOLS);
  localparam int STATE_IDX_W = $clog2(NUM_STATES);
  localparam int Q_W         = CMD_W + SYM_IDX_W + 2 * STATE_IDX_W;

  logic                   accept;
  logic                   push;
  cmd_t                   push_cmd;
  logic [SYM_IDX_W-1:0]   push_sidx;
  logic [STATE_IDX_W-1:0] push_from;
  logic [STATE_IDX_W-1:0] push_to;

  logic                   q_full;
  logic                   q_valid;
  logic                   q_pop;
  logic [Q_W-1:0]         q_head;
  cmd_t                   q_cmd;
  logic [SYM_IDX_W-1:0]   q_sidx;
  logic [STATE_IDX_W-1:0] q_from;
  logic [STATE_IDX_W-1:0] q_to;

  // stall depends on queue occupancy only, never on in_valid
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  nsa_front #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .kind       (kind),
    .slot       (slot),
    .symbol     (symbol),
    .from_state (from_state),
    .to_state   (to_state),
    .push_cmd   (push_cmd),
    .push       (push),
    .push_sidx  (push_sidx),
    .push_from  (push_from),
    .push_to    (push_to)
  );

  nsa_queue #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  ({push_cmd, push_sidx, push_from, push_to}),
    .pop        (q_pop),
    .full       (q_full),
    .head_valid (q_valid),
    .head_data  (q_head)
  );

  assign {q_cmd, q_sidx, q_from, q_to} = q_head;

  nsa_back #(
    .NUM_STATES  (NUM_STATES),
    .NUM_SYMBOLS (NUM_SYMBOLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_sidx    (q_sidx),
    .q_from    (q_from),
    .q_to      (q_to),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .accepted  (accepted)
  );

endmodule

`default_nettype wire

>>> tb/nfa_stream_acceptor_test.sv
// Self-checking bench for nfa_stream_acceptor: a directed word list, then random automata.
// It keeps its own copy of the active-set state and checks every accepted verdict.
// Depends on nsa_pkg and the acceptor RTL.
`default_nettype none

module nfa_stream_acceptor_test;
  import nsa_pkg::*;

  localparam int NSTATE     = DEF_NUM_STATES;
  localparam int NSLOT      = DEF_NUM_SYMBOLS;
  localparam int IDLE_LIMIT = 2000;  // cycles with no word moving on either side
  localparam int DRAIN      = 20;    // queue plus back end, with margin

  // One input word, held in the order that the ports carry it.
  typedef struct {
    kind_t                    kind;
    logic [SLOT_W-1:0]        slot;
    logic [SYMBOL_W-1:0]      symbol;
    logic [STATE_FIELD_W-1:0] src;
    logic [STATE_FIELD_W-1:0] dst;
  } word_t;

  logic                     clk        = 1'b0;
  logic                     rst        = 1'b1;
  logic                     cfg_we     = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]    cfg_data   = '0;
  logic                     in_valid   = 1'b0;
  logic [KIND_W-1:0]        kind       = '0;
  logic [SLOT_W-1:0]        slot       = '0;
  logic [SYMBOL_W-1:0]      symbol     = '0;
  logic [STATE_FIELD_W-1:0] from_state = '0;
  logic [STATE_FIELD_W-1:0] to_state   = '0;
  logic                     out_stall  = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic                     accepted;

  nfa_stream_acceptor u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .slot       (slot),
    .symbol     (symbol),
    .from_state (from_state),
    .to_state   (to_state),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .accepted   (accepted)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Acceptor state as the bench sees it. Transition rows are indexed by
  // [source state][vocabulary slot]; bit d of a row is a move to state d.
  // ---------------------------------------------------------------------------
  logic [SYMBOL_W-1:0] vocab_sym  [NSLOT];
  logic                vocab_ok   [NSLOT];
  logic [NSTATE-1:0]   next_rows  [NSTATE][NSLOT];
  logic [NSTATE-1:0]   live_states = 16'h0001;  // bit zero after reset
  logic [COUNT_W-1:0]  start_count = 5'd1;
  logic [NSTATE-1:0]   accept_mask = '0;

  logic                verdicts_due [$];  // accept bits still to come out
  word_t               pending      [$];  // words not yet put on the port

  // Shadow of the vocabulary as the generator has written it so far, so that
  // random strings can be built mostly from symbols the acceptor knows.
  logic [SYMBOL_W-1:0] gen_sym [NSLOT];
  logic                gen_ok  [NSLOT];

  int  mismatches  = 0;
  int  idle_cycles = 0;
  bit  word_taken  = 1'b0;  // set at the rising edge, read by the driver
  bit  in_calm     = 1'b0;  // no gaps on the input side
  bit  out_calm    = 1'b0;  // no stalls on the result side

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      vocab_sym[i] = '0;
      vocab_ok[i]  = 1'b0;
      gen_sym[i]   = '0;
      gen_ok[i]    = 1'b0;
      for (int s = 0; s < NSTATE; s++)
        next_rows[s][i] = '0;
    end
  end

  // States 0 upward, count saturating at the number of states.
  function automatic logic [NSTATE-1:0] start_set();
    int n;
    n = (start_count > NSTATE) ? NSTATE : start_count;
    return NSTATE'((33'd1 << n) - 1);
  endfunction

  // Lowest valid slot holding the symbol, or -1 when unknown.
  function automatic int slot_of(logic [SYMBOL_W-1:0] sym);
    for (int i = 0; i < NSLOT; i++)
      if (vocab_ok[i] && vocab_sym[i] == sym)
        return i;
    return -1;
  endfunction

  function automatic void set_register(logic [CFG_INDEX_W-1:0] idx,
                                       logic [CFG_DATA_W-1:0] val);
    if (idx == CFG_INITIAL_COUNT) begin
      start_count = val[COUNT_W-1:0];
      live_states = start_set();
    end else if (idx == CFG_FINAL_MASK) begin
      accept_mask = val[FINAL_W-1:0];
    end
  endfunction

  // Advance the automaton by one accepted word; an end word queues a verdict.
  function automatic void step_automaton(word_t w);
    int                idx;
    logic [NSTATE-1:0] nxt;
    case (w.kind)
      KIND_LOAD: begin
        vocab_sym[w.slot] = w.symbol;
        vocab_ok[w.slot]  = 1'b1;
      end
      KIND_ADD: begin
        idx = slot_of(w.symbol);
        if (idx >= 0)
          next_rows[w.src][idx][w.dst] = 1'b1;
      end
      KIND_SYMBOL: begin
        nxt = '0;
        idx = slot_of(w.symbol);
        if (idx >= 0)
          for (int s = 0; s < NSTATE; s++)
            if (live_states[s])
              nxt |= next_rows[s][idx];
        live_states = nxt;  // unknown symbol or no moves: set empties
      end
      default: begin
        verdicts_due.push_back(|(live_states & accept_mask));
        live_states = start_set();
      end
    endcase
  endfunction

  // Gap length: mostly none or short, now and then long.
  function automatic int pause_len(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: falling edge, one word at a time from the pending queue. A word
  // stays on the port until a rising edge takes it.
  // ---------------------------------------------------------------------------
  int    hold_left  = 0;
  int    stall_left = 0;

  always @(negedge clk) begin
    word_t w;
    if (!rst) begin
      if (!in_valid || word_taken) begin
        if (hold_left > 0) begin
          hold_left--;
          in_valid <= 1'b0;
        end else if (pending.size() > 0) begin
          w = pending.pop_front();
          kind       <= w.kind;
          slot       <= w.slot;
          symbol     <= w.symbol;
          from_state <= w.src;
          to_state   <= w.dst;
          in_valid   <= 1'b1;
          hold_left  = pause_len(in_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
      // Result side back-pressure, independent of out_valid.
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pause_len(out_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and watchdog: rising edge. Input words feed the predictor, each
  // accepted result is matched against the oldest outstanding verdict.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    word_t seen;
    logic  want;
    bit    res_taken;
    if (rst) begin
      word_taken  = 1'b0;
      idle_cycles = 0;
    end else begin
      word_taken = in_valid && !in_stall;
      res_taken  = out_valid && !out_stall;
      if (word_taken) begin
        seen.kind   = kind_t'(kind);
        seen.slot   = slot;
        seen.symbol = symbol;
        seen.src    = from_state;
        seen.dst    = to_state;
        step_automaton(seen);
      end
      if (res_taken) begin
        if (verdicts_due.size() == 0) begin
          $error("accepted: no result expected, got %0b", accepted);
          mismatches++;
        end else begin
          want = verdicts_due.pop_front();
          if (accepted !== want) begin
            $error("accepted: expected %0b, got %0b", want, accepted);
            mismatches++;
          end
        end
      end
      if (word_taken || res_taken)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put_word(kind_t k, logic [SLOT_W-1:0] sl, logic [SYMBOL_W-1:0] sy,
                          logic [STATE_FIELD_W-1:0] src, logic [STATE_FIELD_W-1:0] dst);
    word_t w;
    w.kind   = k;
    w.slot   = sl;
    w.symbol = sy;
    w.src    = src;
    w.dst    = dst;
    pending.push_back(w);
    if (k == KIND_LOAD) begin
      gen_sym[sl] = sy;
      gen_ok[sl]  = 1'b1;
    end
  endtask

  // Mostly a symbol in the vocabulary; otherwise any byte (usually unknown).
  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    logic [SYMBOL_W-1:0] known [$];
    for (int i = 0; i < NSLOT; i++)
      if (gen_ok[i])
        known.push_back(gen_sym[i]);
    if (known.size() > 0 && $urandom_range(0, 9) != 0)
      return known[$urandom_range(0, known.size() - 1)];
    return SYMBOL_W'($urandom);
  endfunction

  // Register writes only happen here, with the acceptor idle.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    set_register(idx, val);
  endtask

  // Wait for every word to go in and every verdict to come out, then let
  // the queue and back end drain.
  task automatic settle();
    do
      @(negedge clk);
    while (pending.size() != 0 || in_valid || verdicts_due.size() != 0);
    repeat (DRAIN) @(negedge clk);
  endtask

  // A random automaton fragment followed by strings over it; some noise and
  // stray words mixed in so broken sequences are seen too.
  task automatic random_phase(int n);
    int made;
    int len;
    int r;
    made = 0;
    repeat ($urandom_range(2, 6)) begin
      put_word(KIND_LOAD, SLOT_W'($urandom), ($urandom_range(0, 7) == 0) ? 8'hFF :
               SYMBOL_W'($urandom), STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom));
      made++;
    end
    repeat ($urandom_range(6, 16)) begin
      put_word(KIND_ADD, SLOT_W'($urandom), pick_symbol(),
               STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom));
      made++;
    end
    while (made < n) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        put_word(kind_t'($urandom_range(0, 3)), SLOT_W'($urandom), SYMBOL_W'($urandom),
                 STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom));
        made++;
      end else if (r < 15) begin
        put_word(KIND_ADD, SLOT_W'($urandom), pick_symbol(),
                 STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom));
        made++;
      end else begin
        len = $urandom_range(0, 6);
        repeat (len)
          put_word(KIND_SYMBOL, SLOT_W'($urandom), pick_symbol(),
                   STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom));
        put_word(KIND_END, SLOT_W'($urandom), SYMBOL_W'($urandom),
                 STATE_FIELD_W'($urandom), STATE_FIELD_W'($urandom));
        made += len + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [COUNT_W-1:0] cnt;
    logic [FINAL_W-1:0] fmask;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Reset state: empty string with nothing accepting, then symbol 00 which
    // matches the zeroed but never-loaded slots and so must be unknown.
    put_word(KIND_END,    '0, 8'h00, '0, '0);
    put_word(KIND_SYMBOL, '0, 8'h00, '0, '0);
    put_word(KIND_END,    '0, 8'h00, '0, '0);
    settle();

    write_reg(CFG_FINAL_MASK, 16'h8001);
    write_reg(CFG_INITIAL_COUNT, 16'd1);

    // Duplicate symbol 00 in slots 0 and 3: slot 0 wins. Extreme states.
    put_word(KIND_LOAD, 4'd0,  8'h00, '0, '0);
    put_word(KIND_LOAD, 4'd15, 8'hFF, '0, '0);
    put_word(KIND_LOAD, 4'd3,  8'h00, '0, '0);
    put_word(KIND_ADD,  '0, 8'h00, 4'd0,  4'd15);
    put_word(KIND_ADD,  '0, 8'hFF, 4'd15, 4'd0);
    put_word(KIND_ADD,  '0, 8'h55, 4'd0,  4'd1);   // unknown symbol, dropped
    put_word(KIND_ADD,  '0, 8'h00, 4'd0,  4'd0);
    put_word(KIND_SYMBOL, '0, 8'h00, '0, '0);      // {0,15}
    put_word(KIND_SYMBOL, '0, 8'hFF, '0, '0);      // {0}
    put_word(KIND_END,    '0, 8'h00, '0, '0);      // accept
    put_word(KIND_SYMBOL, '0, 8'hFF, '0, '0);      // state 0 has no FF move
    put_word(KIND_END,    '0, 8'h00, '0, '0);      // reject
    put_word(KIND_SYMBOL, '0, 8'h00, '0, '0);
    put_word(KIND_END,    '0, 8'h00, '0, '0);      // accept via states 0 and 15
    // Known symbol with no transitions at all
    put_word(KIND_LOAD,   4'd7, 8'h55, '0, '0);
    put_word(KIND_SYMBOL, '0, 8'h55, '0, '0);
    put_word(KIND_END,    '0, 8'h00, '0, '0);
    // Slot 0 rewritten: its moves follow AA, and 00 now resolves to slot 3
    put_word(KIND_LOAD,   4'd0, 8'hAA, '0, '0);
    put_word(KIND_SYMBOL, '0, 8'hAA, '0, '0);
    put_word(KIND_SYMBOL, '0, 8'h00, '0, '0);
    put_word(KIND_END,    '0, 8'h00, '0, '0);
    put_word(KIND_SYMBOL, '0, 8'hAA, '0, '0);
    put_word(KIND_END,    '0, 8'h00, '0, '0);
    settle();

    // No initial state, then a count that saturates (upper data bits set).
    write_reg(CFG_INITIAL_COUNT, 16'd0);
    put_word(KIND_END, '0, 8'h00, '0, '0);
    settle();
    write_reg(CFG_INITIAL_COUNT, 16'hFFFF);
    put_word(KIND_END, '0, 8'h00, '0, '0);
    settle();

    for (int ph = 0; ph < 8; ph++) begin
      cnt   = COUNT_W'($urandom_range(0, 31));
      fmask = FINAL_W'((32'd1 << $urandom_range(0, 15)) | (32'd1 << $urandom_range(0, 15)));
      case (ph)
        0: cnt = 5'd1;
        1: begin
          cnt   = 5'd0;
          fmask = 16'hFFFF;
        end
        2: begin
          cnt   = 5'd16;
          fmask = 16'h0000;
        end
        3: begin
          cnt   = 5'd17;
          fmask = 16'h8000;
        end
        4: begin
          cnt   = 5'd16;
          fmask = 16'hFFFF;
        end
        default: ;
      endcase
      in_calm  = (ph == 0) || (ph == 3);
      out_calm = (ph == 0) || (ph == 5);
      write_reg(CFG_INITIAL_COUNT, {11'($urandom), cnt});
      write_reg(CFG_FINAL_MASK, fmask);
      random_phase(150);
      settle();
    end

    if (mismatches == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

`default_nettype wire
